FILE: rtl/vmu_pkg.sv
// Package for the vector magnitude unit: mode codes, payload widths and
// the structure passed from the merge stage into the square-root pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vmu_pkg;

	localparam int COMP_W = 32;
	localparam int ABS_W  = 32;
	localparam int SQ_W   = 64;
	localparam int MAG_W  = 33;
	localparam int ROOT_W = 32;
	localparam int REM_W  = 34;

	typedef enum logic [3:0] {
		MODE_EUCLID3D   = 4'd0,
		MODE_L1_3D      = 4'd1,
		MODE_APPROX13   = 4'd2,
		MODE_APPROX9    = 4'd3,
		MODE_APPROX8    = 4'd4,
		MODE_EUCLID2D   = 4'd5,
		MODE_L1_2D      = 4'd6,
		MODE_MAXHALFMIN = 4'd7,
		MODE_ALPHABETA  = 4'd8
	} mode_t;

	typedef struct packed {
		logic [SQ_W-1:0]  sum;
		logic [MAG_W-1:0] alt;
		logic             use_sqrt;
	} sqrt_req_t;

endpackage

`default_nettype wire

FILE: rtl/vmu_in_if.sv
// Input channel of the vector magnitude unit: mode and three components.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vmu_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         mode;
	logic signed [31:0] comp_x;
	logic signed [31:0] comp_y;
	logic signed [31:0] comp_z;

	modport source (output valid, mode, comp_x, comp_y, comp_z, input ready);
	modport sink   (input valid, mode, comp_x, comp_y, comp_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/vmu_out_if.sv
// Output channel of the vector magnitude unit: one 33-bit magnitude.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vmu_out_if;
	logic        valid;
	logic        ready;
	logic [32:0] magnitude;

	modport source (output valid, magnitude, input ready);
	modport sink   (input valid, magnitude, output ready);
endinterface

`default_nettype wire

FILE: rtl/vmu_lane.sv
// One component lane: absolute value, then its square.
// Depends on vmu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmu_lane (
	input  wire logic                             clk,
	input  wire logic                             en1,
	input  wire logic                             en2,
	input  wire logic signed [vmu_pkg::COMP_W-1:0] comp,
	output logic [vmu_pkg::ABS_W-1:0]              abs_s2,
	output logic [vmu_pkg::SQ_W-1:0]               sq_s2
);
	import vmu_pkg::*;

	logic [ABS_W-1:0] abs_s1;
	logic [ABS_W-1:0] abs_d;

	// The most negative value negates to 2^31, which still fits unsigned.
	assign abs_d = comp[COMP_W-1] ? (~comp + 1'b1) : comp;

	always_ff @(posedge clk) begin
		if (en1) begin
			abs_s1 <= abs_d;
		end
		if (en2) begin
			abs_s2 <= abs_s1;
			sq_s2  <= abs_s1 * abs_s1;
		end
	end
endmodule

`default_nettype wire

FILE: rtl/vmu_merge.sv
// Merge stage: sorts the lane magnitudes, forms the shift approximations
// and the sum of squares for the square-root pipeline. Depends on vmu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmu_merge (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [3:0]                mode,
	input  wire logic [vmu_pkg::ABS_W-1:0] ax,
	input  wire logic [vmu_pkg::ABS_W-1:0] ay,
	input  wire logic [vmu_pkg::ABS_W-1:0] az,
	input  wire logic [vmu_pkg::SQ_W-1:0]  sx,
	input  wire logic [vmu_pkg::SQ_W-1:0]  sy,
	input  wire logic [vmu_pkg::SQ_W-1:0]  sz,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output vmu_pkg::sqrt_req_t             req_s3
);
	import vmu_pkg::*;

	logic [MAG_W-1:0] x, y, z, a1, b1, hi, md, lo, mx2, mn2, alt, t8;
	sqrt_req_t        req_d;

	assign in_ready = !out_valid || out_ready;

	always_comb begin
		x = {1'b0, ax};
		y = {1'b0, ay};
		z = {1'b0, az};
		// Three compare-exchange steps give max, median and min.
		a1 = (x < y) ? y : x;
		b1 = (x < y) ? x : y;
		hi = (a1 < z) ? z : a1;
		lo = (a1 < z) ? a1 : z;
		md = (b1 < lo) ? lo : b1;
		lo = (b1 < lo) ? b1 : lo;
		mx2 = (x > y) ? x : y;
		mn2 = (x > y) ? y : x;
		t8 = mx2 + (mn2 >> 1) - (mx2 >> 5) - (mx2 >> 7)
			- (mn2 >> 4) - (mn2 >> 5) - (mn2 >> 7);
		alt = '0;
		req_d.use_sqrt = 1'b0;
		req_d.sum = sx + sy + sz;
		unique case (mode)
			MODE_EUCLID3D:   req_d.use_sqrt = 1'b1;
			MODE_L1_3D:      alt = x + y + z;
			MODE_APPROX13:   alt = hi + ((md + lo) >> 2);
			MODE_APPROX9:    alt = hi + (md >> 2) + (md >> 4) + (lo >> 2);
			MODE_APPROX8:    alt = hi + (md >> 2) + (md >> 4) + (md >> 5) + (lo >> 2);
			MODE_EUCLID2D: begin
				req_d.use_sqrt = 1'b1;
				req_d.sum      = sx + sy;
			end
			MODE_L1_2D:      alt = x + y;
			MODE_MAXHALFMIN: alt = mx2 + (mn2 >> 1);
			MODE_ALPHABETA:  alt = t8;
			default:         alt = '0;
		endcase
		req_d.alt = alt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s3 <= req_d;
		end
	end
endmodule

`default_nettype wire

FILE: rtl/vmu_sqrt.sv
// Pipelined floor square root, one result bit per stage, carrying the
// approximation result alongside. Depends on vmu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmu_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire vmu_pkg::sqrt_req_t       req,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [vmu_pkg::MAG_W-1:0]     magnitude
);
	import vmu_pkg::*;

	localparam int NS = ROOT_W;

	logic             v_q    [NS];
	logic [SQ_W-1:0]  n_q    [NS];
	logic [REM_W-1:0] rem_q  [NS];
	logic [ROOT_W-1:0] root_q[NS];
	logic [MAG_W-1:0] alt_q  [NS];
	logic             sel_q  [NS];
	logic             rdy    [NS+1];

	assign rdy[NS]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_q[NS-1];
	assign magnitude = sel_q[NS-1] ? {1'b0, root_q[NS-1]} : alt_q[NS-1];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic              pv;
		logic [SQ_W-1:0]   pn;
		logic [REM_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		logic [MAG_W-1:0]  palt;
		logic              psel;
		logic [REM_W+1:0]  rsh, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pn    = req.sum;
			assign prem  = '0;
			assign proot = '0;
			assign palt  = req.alt;
			assign psel  = req.use_sqrt;
		end else begin : g_next
			assign pv    = v_q[k-1];
			assign pn    = n_q[k-1];
			assign prem  = rem_q[k-1];
			assign proot = root_q[k-1];
			assign palt  = alt_q[k-1];
			assign psel  = sel_q[k-1];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign rsh   = {prem, pn[SQ_W-1 -: 2]};
		assign trial = {2'b00, proot, 2'b01};
		assign ge    = rsh >= trial;
		assign rdy[k] = !v_q[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_q[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && pv) begin
				n_q[k]    <= pn << 2;
				rem_q[k]  <= ge ? REM_W'(rsh - trial) : REM_W'(rsh);
				root_q[k] <= {proot[ROOT_W-2:0], ge};
				alt_q[k]  <= palt;
				sel_q[k]  <= psel;
			end
		end
	end
endmodule

`default_nettype wire

FILE: rtl/vector_magnitude_unit.sv
// Top level of the vector magnitude unit: three component lanes, the merge
// stage, the square-root pipeline and the output register.
// Depends on vmu_pkg, vmu_in_if, vmu_out_if, vmu_lane, vmu_merge, vmu_sqrt.
//
//   channel  direction  payload                               handshake
//   vec      in         mode, comp_x, comp_y, comp_z          valid/ready
//   res      out        magnitude (33 bits, unsigned integer) valid/ready
//
// One transaction per cycle sustained unless the output stalls. Stages:
// absolute value, square, merge, 32 square-root (one root bit each), output
// register. Every stage has its own valid bit, so bubbles close up while the
// output stalls. Reset clears only valid bits; no state links transactions.
`timescale 1ns / 1ps
`default_nettype none

module vector_magnitude_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	vmu_in_if.sink    vec,
	vmu_out_if.source res
);
	import vmu_pkg::*;

	logic             v1_q, v2_q, rdy1, rdy2, en1, en2;
	logic [3:0]       mode_s1, mode_s2;
	logic [ABS_W-1:0] ax, ay, az;
	logic [SQ_W-1:0]  sx, sy, sz;
	logic             m_ready, m_valid, s_ready, s_valid;
	sqrt_req_t        req_s3;
	logic [MAG_W-1:0] s_mag, mag_q;
	logic             ov_q;

	assign rdy2      = !v2_q || m_ready;
	assign rdy1      = !v1_q || rdy2;
	assign en1       = rdy1 && vec.valid;
	assign en2       = rdy2 && v1_q;
	assign vec.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= vec.valid;
			if (rdy2) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) mode_s1 <= vec.mode;
		if (en2) mode_s2 <= mode_s1;
	end

	vmu_lane u_lane_x (.clk, .en1, .en2, .comp(vec.comp_x), .abs_s2(ax), .sq_s2(sx));
	vmu_lane u_lane_y (.clk, .en1, .en2, .comp(vec.comp_y), .abs_s2(ay), .sq_s2(sy));
	vmu_lane u_lane_z (.clk, .en1, .en2, .comp(vec.comp_z), .abs_s2(az), .sq_s2(sz));

	vmu_merge u_merge (
		.clk, .arst_n,
		.in_valid(v2_q), .in_ready(m_ready),
		.mode(mode_s2), .ax, .ay, .az, .sx, .sy, .sz,
		.out_valid(m_valid), .out_ready(s_ready), .req_s3
	);

	logic o_rdy;
	assign o_rdy = !ov_q || res.ready;

	vmu_sqrt u_sqrt (
		.clk, .arst_n,
		.in_valid(m_valid), .in_ready(s_ready), .req(req_s3),
		.out_valid(s_valid), .out_ready(o_rdy), .magnitude(s_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (o_rdy) begin
			ov_q <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (o_rdy && s_valid) mag_q <= s_mag;
	end

	assign res.valid     = ov_q;
	assign res.magnitude = mag_q;

	a_first_stage_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> vec.ready) else $error("input stalled with first stage empty");
	a_out_from_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(s_valid)) else $error("result without a root stage");
	a_merge_fed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid) |-> $past(v2_q)) else $error("merge valid without a lane result");
endmodule

`default_nettype wire
